[hdl/ccs_pkg.sv]
// ----------------------------------------------------------------------------
// C comment stripper package
// Shared character codes, state and result group types, and the per-character
// lexing function used by the stripper core.
// ----------------------------------------------------------------------------
`default_nettype none

package ccs_pkg;

   // Character codes.
   localparam logic [7:0] CHAR_NL     = 8'h0A;
   localparam logic [7:0] CHAR_TAB    = 8'h09;
   localparam logic [7:0] CHAR_VT     = 8'h0B;
   localparam logic [7:0] CHAR_FF     = 8'h0C;
   localparam logic [7:0] CHAR_CR     = 8'h0D;
   localparam logic [7:0] CHAR_SPACE  = 8'h20;
   localparam logic [7:0] CHAR_DQUOTE = 8'h22;
   localparam logic [7:0] CHAR_HASH   = 8'h23;
   localparam logic [7:0] CHAR_SQUOTE = 8'h27;
   localparam logic [7:0] CHAR_STAR   = 8'h2A;
   localparam logic [7:0] CHAR_SLASH  = 8'h2F;
   localparam logic [7:0] CHAR_BSLASH = 8'h5C;
   localparam logic [7:0] CHAR_NUL    = 8'h00;

   // Strip mode register codes.
   localparam logic [1:0] MODE_KEEP      = 2'd0;
   localparam logic [1:0] MODE_DIRECTIVE = 2'd1;
   localparam logic [1:0] MODE_RESET     = 2'd2;

   // Results one character can cause.
   localparam int unsigned MAX_RESULTS = 4;
   localparam int unsigned COUNT_W     = $clog2(MAX_RESULTS + 1);
   localparam int unsigned INDEX_W     = $clog2(MAX_RESULTS);

   // Block comment tracking.
   typedef enum logic [3:0] {
      CMT_NONE         = 4'b0001,
      CMT_OPEN_HERE    = 4'b0010,
      CMT_CLOSED_HERE  = 4'b0100,
      CMT_OPEN_EARLIER = 4'b1000
   } cmt_type;

   // Lexer state carried from one character to the next.
   typedef struct packed {
      cmt_type    cmt;
      logic       quote_open;
      logic       quote_dbl;
      logic       escape;
      logic       line_kept;
      logic       line_drop;
      logic [7:0] held_char;
      logic       held_valid;
      logic       seen_nonspace;
      logic       directive;
   } lex_state_type;

   localparam lex_state_type LEX_RESET = '{
      cmt:           CMT_NONE,
      quote_open:    1'b0,
      quote_dbl:     1'b0,
      escape:        1'b0,
      line_kept:     1'b0,
      line_drop:     1'b0,
      held_char:     8'h00,
      held_valid:    1'b0,
      seen_nonspace: 1'b0,
      directive:     1'b0
   };

   // Outcome of handling one plain character.
   typedef struct packed {
      lex_state_type st;
      logic          emit;
      logic [7:0]    ch;
   } plain_out_type;

   // All the results that one input word causes.
   typedef struct packed {
      logic [MAX_RESULTS-1:0][7:0] chars;
      logic [COUNT_W-1:0]          count;
      logic                        done;
      logic                        quote_flag;
      logic                        comment_flag;
   } group_type;

   function automatic logic is_space(logic [7:0] c);
      return (c == CHAR_SPACE) || (c == CHAR_TAB) || (c == CHAR_VT) ||
             (c == CHAR_FF) || (c == CHAR_CR);
   endfunction

   function automatic logic in_comment(cmt_type cs);
      return (cs == CMT_OPEN_HERE) || (cs == CMT_OPEN_EARLIER);
   endfunction

   function automatic logic strip_line(logic [1:0] mode, logic directive);
      return mode[1] || ((mode == MODE_DIRECTIVE) && directive);
   endfunction

   // One character with no pending lookahead.
   function automatic plain_out_type lex_plain(lex_state_type st_i, logic [7:0] c,
                                               logic strip);
      plain_out_type r;
      r.st   = st_i;
      r.emit = 1'b0;
      r.ch   = c;
      if (!st_i.line_drop) begin
         if (st_i.line_kept) begin
            r.emit = 1'b1;
         end else if (st_i.quote_open) begin
            r.emit = 1'b1;
            if (st_i.escape) begin
               r.st.escape = 1'b0;
            end else if (c == CHAR_BSLASH) begin
               r.st.escape = 1'b1;
            end else if (c == (st_i.quote_dbl ? CHAR_DQUOTE : CHAR_SQUOTE)) begin
               r.st.quote_open = 1'b0;
            end
         end else if (in_comment(st_i.cmt)) begin
            if (c == CHAR_STAR) begin
               r.st.held_char  = c;
               r.st.held_valid = 1'b1;
            end else begin
               r.emit = 1'b1;
               r.ch   = strip ? CHAR_SPACE : c;
            end
         end else if (c == CHAR_SLASH) begin
            r.st.held_char  = c;
            r.st.held_valid = 1'b1;
         end else begin
            if ((c == CHAR_DQUOTE) || (c == CHAR_SQUOTE)) begin
               r.st.quote_open = 1'b1;
               r.st.quote_dbl  = (c == CHAR_DQUOTE);
               r.st.escape     = 1'b0;
            end
            r.emit = 1'b1;
         end
      end
      return r;
   endfunction

endpackage

`default_nettype wire

[hdl/ccs_req_if.sv]
// ----------------------------------------------------------------------------
// Source character channel
// Valid/ready channel carrying one source character or the end-of-text mark.
// ----------------------------------------------------------------------------
`default_nettype none

interface ccs_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] in_char;
   logic       end_of_input;

   modport source (output valid, output in_char, output end_of_input, input ready);
   modport sink   (input valid, input in_char, input end_of_input, output ready);
endinterface

`default_nettype wire

[hdl/ccs_rsp_if.sv]
// ----------------------------------------------------------------------------
// Result character channel
// Valid/ready channel carrying one emitted character with its status flags.
// ----------------------------------------------------------------------------
`default_nettype none

interface ccs_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_char;
   logic       char_valid;
   logic       last_of_run;
   logic       quote_unterminated;
   logic       comment_unterminated;
   logic       done_mark;

   modport source (output valid, output out_char, output char_valid, output last_of_run,
                   output quote_unterminated, output comment_unterminated,
                   output done_mark, input ready);
   modport sink   (input valid, input out_char, input char_valid, input last_of_run,
                   input quote_unterminated, input comment_unterminated,
                   input done_mark, output ready);
endinterface

`default_nettype wire

[hdl/ccs_csr_if.sv]
// ----------------------------------------------------------------------------
// Strip mode write channel
// Valid/ready channel writing the strip mode register.
// ----------------------------------------------------------------------------
`default_nettype none

interface ccs_csr_if;
   logic       valid;
   logic       ready;
   logic [1:0] strip_mode;

   modport source (output valid, output strip_mode, input ready);
   modport sink   (input valid, input strip_mode, output ready);
endinterface

`default_nettype wire

[hdl/ccs_lexer.sv]
// ----------------------------------------------------------------------------
// Comment stripping lexer
// Holds the lexer state and the strip mode register, and turns each accepted
// word into a group of up to four result characters combinationally.
// ----------------------------------------------------------------------------
`default_nettype none

module ccs_lexer (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                step_en,
   input  wire logic [7:0]          in_char,
   input  wire logic                end_of_input,
   input  wire logic                cfg_wr,
   input  wire logic [1:0]          cfg_mode,
   output ccs_pkg::group_type       grp,
   output logic                     grp_push
);

   ccs_pkg::lex_state_type state_ff, state_in;
   logic [1:0]             mode_ff, mode_in;

   // Next state and result group for the word on the input.
   always_comb begin
      ccs_pkg::lex_state_type        st;
      ccs_pkg::plain_out_type        po;
      logic                          strip;
      logic [ccs_pkg::COUNT_W-1:0]   n;
      st    = state_ff;
      po    = '0;
      grp   = '0;
      n     = '0;
      strip = ccs_pkg::strip_line(mode_ff, st.directive);
      if (end_of_input || (in_char == ccs_pkg::CHAR_NL)) begin
         // Line or text end: flush the held character, close a kept line comment.
         if (st.held_valid) begin
            grp.chars[n[ccs_pkg::INDEX_W-1:0]] =
               (st.held_char == ccs_pkg::CHAR_STAR) ?
               (strip ? ccs_pkg::CHAR_SPACE : ccs_pkg::CHAR_STAR) : ccs_pkg::CHAR_SLASH;
            n = n + 1'b1;
         end
         if (st.line_kept) begin
            grp.chars[n[ccs_pkg::INDEX_W-1:0]] = ccs_pkg::CHAR_STAR;
            n = n + 1'b1;
            grp.chars[n[ccs_pkg::INDEX_W-1:0]] = ccs_pkg::CHAR_SLASH;
            n = n + 1'b1;
         end
         grp.quote_flag = st.quote_open;
         if (end_of_input) begin
            // Closing word: no character, carries the open-comment flag.
            grp.chars[n[ccs_pkg::INDEX_W-1:0]] = ccs_pkg::CHAR_NUL;
            n = n + 1'b1;
            grp.done         = 1'b1;
            grp.comment_flag = ccs_pkg::in_comment(st.cmt);
            st               = ccs_pkg::LEX_RESET;
         end else begin
            grp.chars[n[ccs_pkg::INDEX_W-1:0]] = ccs_pkg::CHAR_NL;
            n = n + 1'b1;
            st.held_valid    = 1'b0;
            st.quote_open    = 1'b0;
            st.quote_dbl     = 1'b0;
            st.escape        = 1'b0;
            st.line_kept     = 1'b0;
            st.line_drop     = 1'b0;
            st.seen_nonspace = 1'b0;
            st.directive     = 1'b0;
            unique case (st.cmt)
               ccs_pkg::CMT_OPEN_HERE:    st.cmt = ccs_pkg::CMT_OPEN_EARLIER;
               ccs_pkg::CMT_CLOSED_HERE:  st.cmt = ccs_pkg::CMT_NONE;
               ccs_pkg::CMT_NONE:         st.cmt = ccs_pkg::CMT_NONE;
               ccs_pkg::CMT_OPEN_EARLIER: st.cmt = ccs_pkg::CMT_OPEN_EARLIER;
               default:                   st.cmt = ccs_pkg::CMT_NONE;
            endcase
         end
      end else begin
         // The first non-space character decides whether this is a directive line.
         if (!st.seen_nonspace && !ccs_pkg::is_space(in_char)) begin
            st.seen_nonspace = 1'b1;
            st.directive     = (in_char == ccs_pkg::CHAR_HASH);
         end
         strip = ccs_pkg::strip_line(mode_ff, st.directive);
         if (st.held_valid) begin
            st.held_valid = 1'b0;
            if (st.held_char == ccs_pkg::CHAR_SLASH) begin
               if (in_char == ccs_pkg::CHAR_SLASH) begin
                  // Line comment: drop it, or rewrite it as a block comment.
                  if (strip) begin
                     st.line_drop = 1'b1;
                  end else begin
                     grp.chars[n[ccs_pkg::INDEX_W-1:0]] = ccs_pkg::CHAR_SLASH;
                     n = n + 1'b1;
                     grp.chars[n[ccs_pkg::INDEX_W-1:0]] = ccs_pkg::CHAR_STAR;
                     n = n + 1'b1;
                     st.line_kept = 1'b1;
                  end
               end else if (in_char == ccs_pkg::CHAR_STAR) begin
                  st.cmt = ccs_pkg::CMT_OPEN_HERE;
                  grp.chars[n[ccs_pkg::INDEX_W-1:0]] =
                     strip ? ccs_pkg::CHAR_SPACE : ccs_pkg::CHAR_SLASH;
                  n = n + 1'b1;
                  grp.chars[n[ccs_pkg::INDEX_W-1:0]] =
                     strip ? ccs_pkg::CHAR_SPACE : ccs_pkg::CHAR_STAR;
                  n = n + 1'b1;
               end else begin
                  grp.chars[n[ccs_pkg::INDEX_W-1:0]] = ccs_pkg::CHAR_SLASH;
                  n = n + 1'b1;
                  po = ccs_pkg::lex_plain(st, in_char, strip);
                  st = po.st;
                  if (po.emit) begin
                     grp.chars[n[ccs_pkg::INDEX_W-1:0]] = po.ch;
                     n = n + 1'b1;
                  end
               end
            end else begin
               if (in_char == ccs_pkg::CHAR_SLASH) begin
                  // Block comment closer.
                  st.cmt = ccs_pkg::CMT_CLOSED_HERE;
                  grp.chars[n[ccs_pkg::INDEX_W-1:0]] =
                     strip ? ccs_pkg::CHAR_SPACE : ccs_pkg::CHAR_STAR;
                  n = n + 1'b1;
                  grp.chars[n[ccs_pkg::INDEX_W-1:0]] =
                     strip ? ccs_pkg::CHAR_SPACE : ccs_pkg::CHAR_SLASH;
                  n = n + 1'b1;
               end else begin
                  grp.chars[n[ccs_pkg::INDEX_W-1:0]] =
                     strip ? ccs_pkg::CHAR_SPACE : ccs_pkg::CHAR_STAR;
                  n = n + 1'b1;
                  po = ccs_pkg::lex_plain(st, in_char, strip);
                  st = po.st;
                  if (po.emit) begin
                     grp.chars[n[ccs_pkg::INDEX_W-1:0]] = po.ch;
                     n = n + 1'b1;
                  end
               end
            end
         end else begin
            po = ccs_pkg::lex_plain(st, in_char, strip);
            st = po.st;
            if (po.emit) begin
               grp.chars[n[ccs_pkg::INDEX_W-1:0]] = po.ch;
               n = n + 1'b1;
            end
         end
      end
      grp.count = n;
      state_in  = step_en ? st : state_ff;
   end

   // A word that causes no result leaves nothing in the queue.
   assign grp_push = step_en && (grp.count != '0);
   assign mode_in  = cfg_wr ? cfg_mode : mode_ff;

   // Lexer state and strip mode registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ccs_pkg::LEX_RESET;
         mode_ff  <= ccs_pkg::MODE_RESET;
      end else begin
         state_ff <= state_in;
         mode_ff  <= mode_in;
      end
   end

endmodule

`default_nettype wire

[hdl/ccs_result_queue.sv]
// ----------------------------------------------------------------------------
// Result queue and serialiser
// Two result groups (output slot and skid slot); the output slot is sent one
// word per handshake on the result channel.
// ----------------------------------------------------------------------------
`default_nettype none

module ccs_result_queue (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire ccs_pkg::group_type  grp,
   input  wire logic                grp_push,
   output logic                     push_ready,
   ccs_rsp_if.source                rsp_ch
);

   ccs_pkg::group_type            slot0_ff, slot0_in, slot1_ff, slot1_in;
   logic                          slot0_valid_ff, slot0_valid_in;
   logic                          slot1_valid_ff, slot1_valid_in;
   logic [ccs_pkg::INDEX_W-1:0]   idx_ff, idx_in;
   logic                          last;
   logic                          take;
   logic                          pop;

   // Word selection within the output slot.
   assign last = ({1'b0, idx_ff} == (slot0_ff.count - 1'b1));
   assign take = rsp_ch.valid && rsp_ch.ready;
   assign pop  = take && last;

   assign push_ready = !slot1_valid_ff;

   assign rsp_ch.valid                = slot0_valid_ff;
   assign rsp_ch.out_char             = (last && slot0_ff.done) ? ccs_pkg::CHAR_NUL :
                                        slot0_ff.chars[idx_ff];
   assign rsp_ch.char_valid           = !(last && slot0_ff.done);
   assign rsp_ch.last_of_run          = last;
   assign rsp_ch.quote_unterminated   = last && slot0_ff.quote_flag;
   assign rsp_ch.comment_unterminated = last && slot0_ff.comment_flag;
   assign rsp_ch.done_mark            = last && slot0_ff.done;

   // Slot movement: the skid slot refills the output slot when it empties.
   always_comb begin
      slot0_in       = slot0_ff;
      slot1_in       = slot1_ff;
      slot0_valid_in = slot0_valid_ff;
      slot1_valid_in = slot1_valid_ff;
      idx_in         = take ? (last ? '0 : idx_ff + 1'b1) : idx_ff;
      if (!slot0_valid_ff || pop) begin
         if (slot1_valid_ff) begin
            slot0_in       = slot1_ff;
            slot0_valid_in = 1'b1;
            slot1_valid_in = 1'b0;
         end else begin
            slot0_in       = grp;
            slot0_valid_in = grp_push;
         end
      end else if (grp_push) begin
         slot1_in       = grp;
         slot1_valid_in = 1'b1;
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         slot0_valid_ff <= 1'b0;
         slot1_valid_ff <= 1'b0;
         idx_ff         <= '0;
      end else begin
         slot0_valid_ff <= slot0_valid_in;
         slot1_valid_ff <= slot1_valid_in;
         idx_ff         <= idx_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      slot0_ff <= slot0_in;
      slot1_ff <= slot1_in;
   end

endmodule

`default_nettype wire

[hdl/c_comment_stripper_core.sv]
// ----------------------------------------------------------------------------
// C comment stripper core
// Streaming comment stripper for spliced C source text, one byte per word.
//
// Channels: req_ch takes one source byte per word (or the end-of-text mark),
// rsp_ch gives the emitted bytes with their flags, csr_ch writes the strip
// mode (0 keep, 1 strip on directive lines, 2 strip all). Mode writes are
// taken at once and should be made only while the stripper is idle.
// Each input word yields zero to four result words; the last of them is
// marked last_of_run. A '/' outside a comment or a '*' inside one is held back
// one word for lookahead, so its result comes with the following word.
// A word's results are registered in the output slot (or first in the skid
// slot while that is busy) before they are shown. Input words are taken one
// per cycle while the skid slot is empty; results leave one per handshake.
// The lexer decides a whole group combinationally; a two-slot result queue
// sets the rate, and req_ch.ready drops only when both slots hold groups.
// Reset (synchronous) clears the lexer state and the queue and sets the strip
// mode to 2. An end-of-text word closes with a byte-less done word and
// returns the lexer to its reset state, keeping the mode.
// ----------------------------------------------------------------------------
`default_nettype none

module c_comment_stripper_core (
   input  wire logic  clock,
   input  wire logic  reset,
   ccs_req_if.sink    req_ch,
   ccs_rsp_if.source  rsp_ch,
   ccs_csr_if.sink    csr_ch
);

   ccs_pkg::group_type grp;
   logic               grp_push;
   logic               push_ready;
   logic               step_en;

   // Handshakes.
   assign req_ch.ready = push_ready;
   assign csr_ch.ready = 1'b1;
   assign step_en      = req_ch.valid && push_ready;

   // Lexer and state.
   ccs_lexer u_lexer (
      .clock        (clock),
      .reset        (reset),
      .step_en      (step_en),
      .in_char      (req_ch.in_char),
      .end_of_input (req_ch.end_of_input),
      .cfg_wr       (csr_ch.valid),
      .cfg_mode     (csr_ch.strip_mode),
      .grp          (grp),
      .grp_push     (grp_push)
   );

   // Result queue and serialiser.
   ccs_result_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .grp        (grp),
      .grp_push   (grp_push),
      .push_ready (push_ready),
      .rsp_ch     (rsp_ch)
   );

endmodule

`default_nettype wire

[hdl/ccs_checker.sv]
// ----------------------------------------------------------------------------
// C comment stripper port checker
// Checks the result channel of the stripper core over time, attached by bind.
// ----------------------------------------------------------------------------
`default_nettype none

module ccs_checker (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       rsp_valid,
   input wire logic       rsp_ready,
   input wire logic [7:0] out_char,
   input wire logic       char_valid,
   input wire logic       last_of_run,
   input wire logic       quote_unterminated,
   input wire logic       comment_unterminated,
   input wire logic       done_mark
);

   // A stalled result word keeps its contents.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(out_char) &&
      $stable(last_of_run) && $stable(done_mark))
      else $error("result word changed while stalled");

   // The done word carries no byte and closes its run.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && done_mark |-> last_of_run && !char_valid && (out_char == 8'h00))
      else $error("malformed done word");

   // Only the done word is byte-less.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !char_valid |-> done_mark)
      else $error("byte-less word that is not the done word");

   // The open-comment flag appears on the done word only.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && comment_unterminated |-> done_mark)
      else $error("open-comment flag away from the done word");

   // The open-quote flag appears on the last word of a run only.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && quote_unterminated |-> last_of_run)
      else $error("open-quote flag within a run");

endmodule

bind c_comment_stripper_core ccs_checker u_ccs_checker (
   .clock                (clock),
   .reset                (reset),
   .rsp_valid            (rsp_ch.valid),
   .rsp_ready            (rsp_ch.ready),
   .out_char             (rsp_ch.out_char),
   .char_valid           (rsp_ch.char_valid),
   .last_of_run          (rsp_ch.last_of_run),
   .quote_unterminated   (rsp_ch.quote_unterminated),
   .comment_unterminated (rsp_ch.comment_unterminated),
   .done_mark            (rsp_ch.done_mark)
);

`default_nettype wire

[sim/testbench.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Comment stripper core testbench
// Streams directed and random C-like texts through the stripper in every
// strip mode. A scoreboard predicts every result word from its own model
// of the lexer and checks the words in order while both channels idle and
// stall at random.
// ----------------------------------------------------------------------------

module testbench;

   // Mode 3 is not named by the core; it behaves as strip-all.
   localparam logic [1:0] MODE_ALIAS_ALL = 2'd3;
   localparam int         QUIET_LIMIT    = 2000;
   localparam int         PHASE_WORDS    = 28;
   localparam int         HOLD_OFF_LEN   = 80;

   // One result word as seen on the result channel.
   typedef struct packed {
      logic [7:0] out_char;
      logic       char_valid;
      logic       last_of_run;
      logic       quote_unterminated;
      logic       comment_unterminated;
      logic       done_mark;
   } out_word_type;

   // ------------------------------------------------------------------------
   // Scoreboard: predicts the result words of each accepted source word and
   // checks the words leaving the core against them in order.
   // ------------------------------------------------------------------------
   class strip_scoreboard;
      logic [1:0]       mode      = ccs_pkg::MODE_RESET;
      ccs_pkg::cmt_type cmt       = ccs_pkg::CMT_NONE;
      logic             q_open    = 1'b0;
      logic             q_dbl     = 1'b0;
      logic             esc       = 1'b0;
      logic             kept      = 1'b0;
      logic             drop      = 1'b0;
      logic [7:0]       held_ch   = 8'h00;
      logic             held_v    = 1'b0;
      logic             seen_ns   = 1'b0;
      logic             directive = 1'b0;
      out_word_type     group_q[$];
      out_word_type     expected_q[$];
      int               mismatches    = 0;
      int               checked       = 0;
      int               words         = 0;
      int               texts         = 0;
      int               quote_flags   = 0;
      int               comment_flags = 0;

      function void clear_lexer();
         cmt       = ccs_pkg::CMT_NONE;
         q_open    = 1'b0;
         q_dbl     = 1'b0;
         esc       = 1'b0;
         kept      = 1'b0;
         drop      = 1'b0;
         held_ch   = 8'h00;
         held_v    = 1'b0;
         seen_ns   = 1'b0;
         directive = 1'b0;
      endfunction

      function logic stripping();
         return mode[1] || ((mode == ccs_pkg::MODE_DIRECTIVE) && directive);
      endfunction

      function logic in_cmt();
         return (cmt == ccs_pkg::CMT_OPEN_HERE) || (cmt == ccs_pkg::CMT_OPEN_EARLIER);
      endfunction

      // At most four words per source word; further ones are lost.
      function void emit(logic [7:0] c);
         out_word_type w;
         if (group_q.size() >= ccs_pkg::MAX_RESULTS) return;
         w            = '0;
         w.out_char   = c;
         w.char_valid = 1'b1;
         group_q.push_back(w);
      endfunction

      // A character with nothing held back.
      function void lex_char(logic [7:0] c);
         if (drop) return;
         if (kept) begin
            emit(c);
            return;
         end
         if (q_open) begin
            emit(c);
            if (esc) esc = 1'b0;
            else if (c == ccs_pkg::CHAR_BSLASH) esc = 1'b1;
            else if (c == (q_dbl ? ccs_pkg::CHAR_DQUOTE : ccs_pkg::CHAR_SQUOTE))
               q_open = 1'b0;
            return;
         end
         if (in_cmt()) begin
            if (c == ccs_pkg::CHAR_STAR) begin
               held_ch = c;
               held_v  = 1'b1;
            end else begin
               emit(stripping() ? ccs_pkg::CHAR_SPACE : c);
            end
            return;
         end
         if (c == ccs_pkg::CHAR_SLASH) begin
            held_ch = c;
            held_v  = 1'b1;
         end else begin
            if ((c == ccs_pkg::CHAR_DQUOTE) || (c == ccs_pkg::CHAR_SQUOTE)) begin
               q_open = 1'b1;
               q_dbl  = (c == ccs_pkg::CHAR_DQUOTE);
               esc    = 1'b0;
            end
            emit(c);
         end
      endfunction

      // A character following a held '/' or '*'.
      function void lex_pair(logic [7:0] c);
         logic [7:0] h;
         h      = held_ch;
         held_v = 1'b0;
         if (h == ccs_pkg::CHAR_SLASH) begin
            if (c == ccs_pkg::CHAR_SLASH) begin
               if (stripping()) begin
                  drop = 1'b1;
               end else begin
                  emit(ccs_pkg::CHAR_SLASH);
                  emit(ccs_pkg::CHAR_STAR);
                  kept = 1'b1;
               end
            end else if (c == ccs_pkg::CHAR_STAR) begin
               cmt = ccs_pkg::CMT_OPEN_HERE;
               emit(stripping() ? ccs_pkg::CHAR_SPACE : ccs_pkg::CHAR_SLASH);
               emit(stripping() ? ccs_pkg::CHAR_SPACE : ccs_pkg::CHAR_STAR);
            end else begin
               emit(ccs_pkg::CHAR_SLASH);
               lex_char(c);
            end
         end else begin
            if (c == ccs_pkg::CHAR_SLASH) begin
               cmt = ccs_pkg::CMT_CLOSED_HERE;
               emit(stripping() ? ccs_pkg::CHAR_SPACE : ccs_pkg::CHAR_STAR);
               emit(stripping() ? ccs_pkg::CHAR_SPACE : ccs_pkg::CHAR_SLASH);
            end else begin
               emit(stripping() ? ccs_pkg::CHAR_SPACE : ccs_pkg::CHAR_STAR);
               lex_char(c);
            end
         end
      endfunction

      function void flush_held();
         if (!held_v) return;
         held_v = 1'b0;
         if (held_ch == ccs_pkg::CHAR_STAR)
            emit(stripping() ? ccs_pkg::CHAR_SPACE : ccs_pkg::CHAR_STAR);
         else emit(ccs_pkg::CHAR_SLASH);
      endfunction

      // Note an accepted source word and queue the words it should cause.
      function void note_word(logic [7:0] c, logic eoi);
         out_word_type w;
         logic         qf;
         logic         cf;
         int           idx;
         group_q.delete();
         words++;
         if (eoi) begin
            flush_held();
            if (kept) begin
               emit(ccs_pkg::CHAR_STAR);
               emit(ccs_pkg::CHAR_SLASH);
            end
            qf = q_open;
            cf = in_cmt();
            emit(ccs_pkg::CHAR_NUL);
            idx                    = group_q.size() - 1;
            w                      = group_q[idx];
            w.char_valid           = 1'b0;
            w.quote_unterminated   = qf;
            w.comment_unterminated = cf;
            w.done_mark            = 1'b1;
            group_q[idx]           = w;
            texts++;
            quote_flags   += qf;
            comment_flags += cf;
            clear_lexer();
         end else if (c == ccs_pkg::CHAR_NL) begin
            flush_held();
            if (kept) begin
               emit(ccs_pkg::CHAR_STAR);
               emit(ccs_pkg::CHAR_SLASH);
            end
            emit(ccs_pkg::CHAR_NL);
            idx                  = group_q.size() - 1;
            w                    = group_q[idx];
            w.quote_unterminated = q_open;
            group_q[idx]         = w;
            quote_flags += q_open;
            q_open    = 1'b0;
            q_dbl     = 1'b0;
            esc       = 1'b0;
            kept      = 1'b0;
            drop      = 1'b0;
            seen_ns   = 1'b0;
            directive = 1'b0;
            if (cmt == ccs_pkg::CMT_OPEN_HERE) cmt = ccs_pkg::CMT_OPEN_EARLIER;
            else if (cmt == ccs_pkg::CMT_CLOSED_HERE) cmt = ccs_pkg::CMT_NONE;
         end else begin
            if (!seen_ns && !((c == ccs_pkg::CHAR_SPACE) || (c == ccs_pkg::CHAR_TAB) ||
                              (c == ccs_pkg::CHAR_VT) || (c == ccs_pkg::CHAR_FF) ||
                              (c == ccs_pkg::CHAR_CR))) begin
               seen_ns   = 1'b1;
               directive = (c == ccs_pkg::CHAR_HASH);
            end
            if (held_v) lex_pair(c);
            else lex_char(c);
         end
         if (group_q.size() > 0) begin
            idx           = group_q.size() - 1;
            w             = group_q[idx];
            w.last_of_run = 1'b1;
            group_q[idx]  = w;
         end
         foreach (group_q[i]) expected_q.push_back(group_q[i]);
      endfunction

      function string show(out_word_type w);
         return $sformatf("char=%h valid=%b last=%b quote=%b comment=%b done=%b",
                          w.out_char, w.char_valid, w.last_of_run,
                          w.quote_unterminated, w.comment_unterminated, w.done_mark);
      endfunction

      // Compare one result word with the oldest expectation.
      function void check_word(out_word_type got);
         out_word_type want;
         logic         bad;
         checked++;
         if (expected_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("ERROR: unexpected result word at %0t: %s", $realtime, show(got));
            return;
         end
         want = expected_q.pop_front();
         bad  = (got.out_char !== want.out_char) ||
                (got.char_valid !== want.char_valid) ||
                (got.last_of_run !== want.last_of_run) ||
                (got.quote_unterminated !== want.quote_unterminated) ||
                (got.comment_unterminated !== want.comment_unterminated) ||
                (got.done_mark !== want.done_mark);
         if (bad) begin
            mismatches++;
            if (mismatches <= 10) begin
               $display("ERROR: result word %0d at %0t", checked, $realtime);
               $display("   expected %s", show(want));
               $display("   actual   %s", show(got));
            end
         end
      endfunction

      function int pending();
         return expected_q.size();
      endfunction
   endclass

   logic clock;
   logic reset;

   ccs_req_if req_if ();
   ccs_rsp_if rsp_if ();
   ccs_csr_if csr_if ();

   c_comment_stripper_core dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_if),
      .rsp_ch (rsp_if),
      .csr_ch (csr_if)
   );

   strip_scoreboard sb = new;

   int send_idle_pct  = 0;
   int recv_stall_pct = 0;
   bit hold_off_req   = 1'b0;
   int hold_off_left  = 0;
   int quiet_cycles   = 0;

   // Clock generation.
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Result side: check accepted words and decide ready for the next cycle.
   always @(posedge clock) begin : result_side
      out_word_type got;
      if (rsp_if.valid && rsp_if.ready) begin
         got.out_char             = rsp_if.out_char;
         got.char_valid           = rsp_if.char_valid;
         got.last_of_run          = rsp_if.last_of_run;
         got.quote_unterminated   = rsp_if.quote_unterminated;
         got.comment_unterminated = rsp_if.comment_unterminated;
         got.done_mark            = rsp_if.done_mark;
         sb.check_word(got);
      end
      if (hold_off_req) begin
         hold_off_left = HOLD_OFF_LEN;
         hold_off_req  = 1'b0;
      end
      if (reset) begin
         rsp_if.ready <= 1'b0;
      end else if (hold_off_left > 0) begin
         rsp_if.ready <= 1'b0;
         hold_off_left--;
      end else begin
         rsp_if.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
      end
   end

   // Watchdog: too long without any word moving on any channel.
   always @(posedge clock) begin
      if (reset || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready) ||
          (csr_if.valid && csr_if.ready)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("ERROR: no progress for %0d cycles, %0d words still expected",
                     QUIET_LIMIT, sb.pending());
            $display("Test completed with failures");
            $finish;
         end
      end
   end

   // Offer one source word, with random idle cycles ahead of it.
   task automatic send_word(input logic [7:0] c, input logic eoi);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_if.valid <= 1'b0;
         @(posedge clock);
      end
      req_if.valid        <= 1'b1;
      req_if.in_char      <= c;
      req_if.end_of_input <= eoi;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      sb.note_word(c, eoi);
   endtask

   task automatic send_text(input string s, input bit close_text);
      for (int i = 0; i < s.len(); i++) send_word(s[i], 1'b0);
      if (close_text) send_word(8'($urandom_range(0, 255)), 1'b1);
   endtask

   task automatic wait_drained();
      req_if.valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
   endtask

   // Mode writes only while the core is idle, after the last result word has left.
   task automatic write_mode(input logic [1:0] m);
      wait_drained();
      repeat (4) @(posedge clock);
      csr_if.valid      <= 1'b1;
      csr_if.strip_mode <= m;
      @(posedge clock);
      while (!csr_if.ready) @(posedge clock);
      csr_if.valid <= 1'b0;
      sb.mode = m;
   endtask

   function automatic logic [7:0] any_letter();
      return 8'($urandom_range(8'h61, 8'h7A));
   endfunction

   // Append one token of C-like text: mostly well-formed lexemes, some noise.
   function automatic void add_token(ref logic [7:0] t[$]);
      int r;
      int n;
      r = $urandom_range(0, 99);
      if (r < 12) begin
         t.push_back(any_letter());
      end else if (r < 19) begin
         case ($urandom_range(0, 4))
            0: t.push_back(ccs_pkg::CHAR_SPACE);
            1: t.push_back(ccs_pkg::CHAR_TAB);
            2: t.push_back(ccs_pkg::CHAR_VT);
            3: t.push_back(ccs_pkg::CHAR_FF);
            default: t.push_back(ccs_pkg::CHAR_CR);
         endcase
      end else if (r < 29) begin
         // Line ends often start a directive line.
         t.push_back(ccs_pkg::CHAR_NL);
         if ($urandom_range(0, 99) < 40) begin
            if ($urandom_range(0, 1)) t.push_back(ccs_pkg::CHAR_SPACE);
            t.push_back(ccs_pkg::CHAR_HASH);
         end
      end else if (r < 37) begin
         t.push_back(ccs_pkg::CHAR_SLASH);
         t.push_back(ccs_pkg::CHAR_STAR);
      end else if (r < 45) begin
         t.push_back(ccs_pkg::CHAR_STAR);
         t.push_back(ccs_pkg::CHAR_SLASH);
      end else if (r < 52) begin
         t.push_back(ccs_pkg::CHAR_SLASH);
         t.push_back(ccs_pkg::CHAR_SLASH);
      end else if (r < 57) begin
         t.push_back(ccs_pkg::CHAR_SLASH);
      end else if (r < 62) begin
         t.push_back(ccs_pkg::CHAR_STAR);
      end else if (r < 70) begin
         // String literal, sometimes left open.
         t.push_back(ccs_pkg::CHAR_DQUOTE);
         n = $urandom_range(0, 6);
         repeat (n) begin
            case ($urandom_range(0, 5))
               0: begin
                  t.push_back(ccs_pkg::CHAR_BSLASH);
                  t.push_back($urandom_range(0, 1) ? ccs_pkg::CHAR_DQUOTE :
                                                     ccs_pkg::CHAR_BSLASH);
               end
               1: t.push_back(ccs_pkg::CHAR_SLASH);
               2: t.push_back(ccs_pkg::CHAR_STAR);
               3: t.push_back(ccs_pkg::CHAR_SQUOTE);
               default: t.push_back(any_letter());
            endcase
         end
         if ($urandom_range(0, 99) < 80) t.push_back(ccs_pkg::CHAR_DQUOTE);
      end else if (r < 76) begin
         // Character literal.
         t.push_back(ccs_pkg::CHAR_SQUOTE);
         if ($urandom_range(0, 1)) begin
            t.push_back(ccs_pkg::CHAR_BSLASH);
            t.push_back($urandom_range(0, 1) ? ccs_pkg::CHAR_SQUOTE : any_letter());
         end else begin
            t.push_back($urandom_range(0, 1) ? ccs_pkg::CHAR_DQUOTE : any_letter());
         end
         if ($urandom_range(0, 99) < 85) t.push_back(ccs_pkg::CHAR_SQUOTE);
      end else if (r < 81) begin
         t.push_back(ccs_pkg::CHAR_HASH);
      end else if (r < 85) begin
         t.push_back(ccs_pkg::CHAR_BSLASH);
      end else if (r < 93) begin
         t.push_back(8'($urandom_range(0, 255)));
      end else begin
         // Opener followed by a slash, or a run of stars before a closer.
         if ($urandom_range(0, 1)) begin
            t.push_back(ccs_pkg::CHAR_SLASH);
            t.push_back(ccs_pkg::CHAR_STAR);
            t.push_back(ccs_pkg::CHAR_SLASH);
         end else begin
            t.push_back(ccs_pkg::CHAR_STAR);
            t.push_back(ccs_pkg::CHAR_STAR);
            t.push_back(ccs_pkg::CHAR_SLASH);
         end
      end
   endfunction

   // Main sequence.
   initial begin : stimulus
      logic [1:0] phase_mode[8];
      logic [7:0] text_q[$];
      int         phase_cnt;
      int         target;
      bit         held_off;
      bit         paused;
      phase_mode = '{ccs_pkg::MODE_KEEP, ccs_pkg::MODE_DIRECTIVE, ccs_pkg::MODE_RESET,
                     MODE_ALIAS_ALL, ccs_pkg::MODE_DIRECTIVE, ccs_pkg::MODE_KEEP,
                     ccs_pkg::MODE_RESET, ccs_pkg::MODE_DIRECTIVE};
      held_off = 1'b0;
      paused   = 1'b0;

      reset               <= 1'b1;
      req_if.valid        <= 1'b0;
      req_if.in_char      <= 8'h00;
      req_if.end_of_input <= 1'b0;
      csr_if.valid        <= 1'b0;
      csr_if.strip_mode   <= ccs_pkg::MODE_RESET;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed text in the reset mode: an opener whose star must not close,
      // an escaped quote left open at the line end, a directive line comment,
      // the extreme byte values, and a comment still open at end of text.
      send_text("/*/x*/", 1'b0);
      send_text("\"\\\"\n", 1'b0);
      send_text("#//z\n", 1'b0);
      send_word(ccs_pkg::CHAR_NUL, 1'b0);
      send_word(8'hFF, 1'b0);
      send_text("/*", 1'b1);
      // A line comment kept as a block comment, closed at end of text.
      write_mode(ccs_pkg::MODE_KEEP);
      send_text("//a", 1'b1);

      // Random texts under every mode and idling pattern.
      for (int p = 0; p < 8; p++) begin
         write_mode(phase_mode[p]);
         case (p % 4)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 88; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 88; end
            default: begin send_idle_pct = 33; recv_stall_pct = 33; end
         endcase
         phase_cnt = 0;
         while (phase_cnt < PHASE_WORDS) begin
            // Fill the core while results are held off, and later let it drain.
            if (p == 0 && !held_off && phase_cnt > 8) begin
               hold_off_req = 1'b1;
               held_off     = 1'b1;
            end
            if (p == 4 && !paused && phase_cnt > 15) begin
               wait_drained();
               paused = 1'b1;
            end
            text_q.delete();
            target = $urandom_range(3, 20);
            while (text_q.size() < target) add_token(text_q);
            foreach (text_q[i]) send_word(text_q[i], 1'b0);
            phase_cnt += text_q.size();
            if (phase_cnt >= PHASE_WORDS || $urandom_range(0, 99) < 70) begin
               send_word(8'($urandom_range(0, 255)), 1'b1);
               phase_cnt++;
            end
         end
      end

      wait_drained();
      repeat (10) @(posedge clock);
      sb.mismatches += sb.pending();
      $display("Fed %0d source words as %0d texts through all strip modes; %0d result words",
               sb.words, sb.texts, sb.checked);
      $display("checked, with %0d open quotes and %0d open comments flagged.",
               sb.quote_flags, sb.comment_flags);
      if (sb.mismatches == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule

[files.f]
hdl/ccs_pkg.sv
hdl/ccs_req_if.sv
hdl/ccs_rsp_if.sv
hdl/ccs_csr_if.sv
hdl/ccs_lexer.sv
hdl/ccs_result_queue.sv
hdl/c_comment_stripper_core.sv
hdl/ccs_checker.sv
sim/testbench.sv
